// ===== hdl/mrcp_pkg.sv =====
// ----------------------------------------------------------------------------
// mrcp_pkg
// Shared types and character codes for the motor rate command parser.
// ----------------------------------------------------------------------------
package mrcp_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_M     = 8'h4D;

  localparam int unsigned MAG_W = 16;
  localparam logic [MAG_W-1:0] MAG_LIMIT = 16'h8000;
  localparam logic [MAG_W-1:0] RATE_MAX  = 16'h7FFF;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } stage_t;

  typedef struct packed {
    logic               emit;
    logic               command_valid;
    logic [1:0]         motor_select;
    logic signed [15:0] step_rate;
  } result_t;

endpackage

// ===== hdl/mrcp_if.sv =====
// ----------------------------------------------------------------------------
// mrcp_byte_if / mrcp_cmd_if
// Valid/ready channels for received bytes and parsed commands.
// ----------------------------------------------------------------------------
interface mrcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mrcp_cmd_if;
  logic               valid;
  logic               ready;
  logic               command_valid;
  logic [1:0]         motor_select;
  logic signed [15:0] step_rate;

  modport source (output valid, output command_valid, output motor_select,
                  output step_rate, input ready);
  modport sink (input valid, input command_valid, input motor_select,
                input step_rate, output ready);
endinterface

// ===== hdl/mrcp_in_reg.sv =====
// ----------------------------------------------------------------------------
// mrcp_in_reg
// Input register: captures one received byte word per cycle while it is empty or the parse stage advances.
// ----------------------------------------------------------------------------
module mrcp_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  mrcp_byte_if.sink       in_byte,
  input  logic            advance,
  output mrcp_pkg::stage_t stage
);
  import mrcp_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       accept;

  assign in_byte.ready = !valid_r || advance;
  assign accept        = in_byte.valid && in_byte.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_byte.rx_byte;
    end
  end

  assign stage.valid   = valid_r;
  assign stage.rx_byte = byte_r;

endmodule

// ===== hdl/mrcp_core.sv =====
// ----------------------------------------------------------------------------
// mrcp_core
// Line state and single-pass parse of one byte; emits a command on newline.
// ----------------------------------------------------------------------------
module mrcp_core #(
  parameter int unsigned LINE_CAPACITY = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mrcp_pkg::stage_t  stage,
  input  logic              advance,
  output mrcp_pkg::result_t result
);
  import mrcp_pkg::*;

  localparam int unsigned CW = $clog2(LINE_CAPACITY);
  localparam logic [CW-1:0] LAST = CW'(LINE_CAPACITY - 1);

  logic [CW-1:0]    count_r, count_nxt;
  logic             ended_r, ended_nxt;
  logic             leader_r, leader_nxt;
  logic [1:0]       motor_r, motor_nxt;
  logic             motor_ok_r, motor_ok_nxt;
  logic             letter_r, letter_nxt;
  phase_t           phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;

  logic             step;
  logic [7:0]       c;
  logic             is_digit;
  logic             is_space;
  logic [MAG_W+3:0] mag_sum;
  logic [MAG_W-1:0] mag_add;
  logic             cmd_ok;

  assign step     = stage.valid && advance;
  assign c        = stage.rx_byte;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign mag_sum  = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0} + {16'd0, c[3:0]};
  assign mag_add  = (mag_sum > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : mag_sum[MAG_W-1:0];
  assign cmd_ok   = leader_r && motor_ok_r && letter_r;

  always_comb begin
    count_nxt    = count_r;
    ended_nxt    = ended_r;
    leader_nxt   = leader_r;
    motor_nxt    = motor_r;
    motor_ok_nxt = motor_ok_r;
    letter_nxt   = letter_r;
    phase_nxt    = phase_r;
    neg_nxt      = neg_r;
    mag_nxt      = mag_r;
    result       = '0;
    if (step) begin
      if (c == CH_NL) begin
        result.emit          = 1'b1;
        result.command_valid = cmd_ok;
        if (cmd_ok) begin
          result.motor_select = motor_r;
          if (neg_r) begin
            result.step_rate = $signed(16'(16'd0 - mag_r));
          end else begin
            result.step_rate = $signed((mag_r > RATE_MAX) ? RATE_MAX : mag_r);
          end
        end
        count_nxt    = '0;
        ended_nxt    = 1'b0;
        leader_nxt   = 1'b0;
        motor_nxt    = '0;
        motor_ok_nxt = 1'b0;
        letter_nxt   = 1'b0;
        phase_nxt    = PH_SKIP;
        neg_nxt      = 1'b0;
        mag_nxt      = '0;
      end else if (count_r != LAST) begin
        count_nxt = count_r + 1'b1;
        if (!ended_r) begin
          if (c == CH_NUL) begin
            ended_nxt = 1'b1;
          end else begin
            if (count_r == '0) begin
              leader_nxt = (c == CH_M);
            end else if (count_r == CW'(1)) begin
              if ((c >= CH_ZERO) && (c <= CH_THREE)) begin
                motor_ok_nxt = 1'b1;
                motor_nxt    = c[1:0];
              end
            end
            if (letter_r) begin
              case (phase_r)
                PH_SKIP: begin
                  if (is_space) begin
                    phase_nxt = PH_SKIP;
                  end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                    neg_nxt   = (c == CH_MINUS);
                    phase_nxt = PH_SIGN;
                  end else if (is_digit) begin
                    mag_nxt   = mag_add;
                    phase_nxt = PH_DIGITS;
                  end else begin
                    phase_nxt = PH_DONE;
                  end
                end
                PH_SIGN, PH_DIGITS: begin
                  if (is_digit) begin
                    mag_nxt   = mag_add;
                    phase_nxt = PH_DIGITS;
                  end else begin
                    phase_nxt = PH_DONE;
                  end
                end
                default: begin
                  phase_nxt = phase_r;
                end
              endcase
            end else if (c == CH_F) begin
              letter_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      ended_r    <= 1'b0;
      leader_r   <= 1'b0;
      motor_r    <= '0;
      motor_ok_r <= 1'b0;
      letter_r   <= 1'b0;
      phase_r    <= PH_SKIP;
      neg_r      <= 1'b0;
      mag_r      <= '0;
    end else begin
      count_r    <= count_nxt;
      ended_r    <= ended_nxt;
      leader_r   <= leader_nxt;
      motor_r    <= motor_nxt;
      motor_ok_r <= motor_ok_nxt;
      letter_r   <= letter_nxt;
      phase_r    <= phase_nxt;
      neg_r      <= neg_nxt;
      mag_r      <= mag_nxt;
    end
  end

endmodule

// ===== hdl/mrcp_out_reg.sv =====
// ----------------------------------------------------------------------------
// mrcp_out_reg
// Result register: holds one command word until the sink takes it.
// ----------------------------------------------------------------------------
module mrcp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  mrcp_pkg::result_t result,
  output logic              advance,
  mrcp_cmd_if.source        out_cmd
);
  import mrcp_pkg::*;

  logic               valid_r, valid_nxt;
  logic               cmd_valid_r;
  logic [1:0]         motor_r;
  logic signed [15:0] rate_r;
  logic               load;

  assign advance = !valid_r || out_cmd.ready;
  assign load    = result.emit && advance;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_cmd.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_valid_r <= result.command_valid;
      motor_r     <= result.motor_select;
      rate_r      <= result.step_rate;
    end
  end

  assign out_cmd.valid         = valid_r;
  assign out_cmd.command_valid = cmd_valid_r;
  assign out_cmd.motor_select  = motor_r;
  assign out_cmd.step_rate     = rate_r;

endmodule

// ===== hdl/motor_rate_command_parser.sv =====
// ----------------------------------------------------------------------------
// motor_rate_command_parser
// Parses newline-ended "M<d>...F<number>" lines into motor rate commands.
// ----------------------------------------------------------------------------
// One byte word is taken every cycle while the command sink keeps up. Each
// byte is registered and then parsed in one pass against the line state. A
// newline passes through the input register and, when the parse stage
// advances, loads a command word into the result register as valid. The
// only stall comes from the result register. While a command word waits
// unread, the parse stage holds and the input takes at most one more byte.
// Only the first LINE_CAPACITY-1 bytes of a line are parsed, and the rate
// saturates to 16 bits.
module motor_rate_command_parser #(
  parameter int unsigned LINE_CAPACITY = 32
) (
  input logic        clk,
  input logic        rst_n,
  mrcp_byte_if.sink  in_byte,
  mrcp_cmd_if.source out_cmd
);
  import mrcp_pkg::*;

  stage_t  stage;
  result_t result;
  logic    advance;

  mrcp_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_byte (in_byte),
    .advance (advance),
    .stage   (stage)
  );

  mrcp_core #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage   (stage),
    .advance (advance),
    .result  (result)
  );

  mrcp_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .result  (result),
    .advance (advance),
    .out_cmd (out_cmd)
  );

  a_newline_loads: assert property (@(posedge clk) disable iff (!rst_n)
    stage.valid && advance && (stage.rx_byte == CH_NL) |=> out_cmd.valid)
    else $error("newline did not load a command word");

  a_plain_byte_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    !out_cmd.valid && !(stage.valid && (stage.rx_byte == CH_NL)) |=> !out_cmd.valid)
    else $error("command word appeared without a newline");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !stage.valid |-> in_byte.ready)
    else $error("input stalled with an empty stage");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    result.emit && !result.command_valid |->
      (result.motor_select == 2'd0) && (result.step_rate == 16'sd0))
    else $error("invalid command carries nonzero fields");

endmodule

// ===== dv/motor_rate_command_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_rate_command_parser_tb
// Streams byte words into the command parser and checks each command word
// against a line parser kept in the bench. Directed lines cover the field
// extremes and malformed, cut and overlong lines. Random lines follow under
// three idle patterns, with one long output stall that backs up the input.
// ----------------------------------------------------------------------------
module motor_rate_command_parser_tb;
  import mrcp_pkg::*;

  localparam int unsigned LINE_CAP     = 32;
  localparam int unsigned CLK_HALF     = 2;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam logic [7:0]  CH_VT        = 8'h0B;
  localparam logic [7:0]  CH_FF        = 8'h0C;

  typedef struct packed {
    logic               command_valid;
    logic [1:0]         motor_select;
    logic signed [15:0] step_rate;
  } rate_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #(CLK_HALF) clk = ~clk;

  mrcp_byte_if byte_if ();
  mrcp_cmd_if  cmd_if ();

  motor_rate_command_parser #(
    .LINE_CAPACITY(LINE_CAP)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_byte (byte_if),
    .out_cmd (cmd_if)
  );

  // line state of the bench parser
  int unsigned line_len;
  logic        text_cut;
  logic        lead_m;
  logic [1:0]  motor_num;
  logic        motor_seen;
  logic        f_seen;
  phase_t      rate_phase;
  logic        rate_neg;
  int unsigned magnitude;

  rate_cmd_t   expected_cmds[$];
  logic [7:0]  line_buf[$];

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  logic        sink_hold;
  int unsigned quiet_cycles;
  int unsigned errors;
  int unsigned bytes_taken;
  int unsigned lines_seen;
  int unsigned valid_cmds;
  int unsigned limit_rates;

  function automatic void clear_line();
    line_len   = 0;
    text_cut   = 1'b0;
    lead_m     = 1'b0;
    motor_num  = '0;
    motor_seen = 1'b0;
    f_seen     = 1'b0;
    rate_phase = PH_SKIP;
    rate_neg   = 1'b0;
    magnitude  = 0;
  endfunction

  function automatic void add_rate_digit(input logic [7:0] ch);
    int unsigned v;
    v = magnitude * 10 + int'(ch - CH_ZERO);
    magnitude = (v > MAG_LIMIT) ? MAG_LIMIT : v;
    rate_phase = PH_DIGITS;
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] ch);
    rate_cmd_t cmd;
    logic      is_digit;
    logic      is_space;
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    bytes_taken++;
    if (ch == CH_NL) begin
      cmd = '0;
      lines_seen++;
      if (lead_m && motor_seen && f_seen) begin
        cmd.command_valid = 1'b1;
        cmd.motor_select  = motor_num;
        if (rate_neg) begin
          cmd.step_rate = 16'(0 - magnitude);
        end else begin
          cmd.step_rate = (magnitude > RATE_MAX) ? RATE_MAX : 16'(magnitude);
        end
        valid_cmds++;
        if (magnitude >= MAG_LIMIT) limit_rates++;
      end
      expected_cmds.push_back(cmd);
      clear_line();
    end else if (line_len < LINE_CAP - 1) begin
      if (!text_cut) begin
        if (ch == CH_NUL) begin
          text_cut = 1'b1;
        end else begin
          if (line_len == 0) begin
            lead_m = (ch == CH_M);
          end else if (line_len == 1 && ch >= CH_ZERO && ch <= CH_THREE) begin
            motor_seen = 1'b1;
            motor_num  = 2'(ch - CH_ZERO);
          end
          if (f_seen) begin
            case (rate_phase)
              PH_SKIP: begin
                if (ch == CH_PLUS || ch == CH_MINUS) begin
                  rate_neg   = (ch == CH_MINUS);
                  rate_phase = PH_SIGN;
                end else if (is_digit) begin
                  add_rate_digit(ch);
                end else if (!is_space) begin
                  rate_phase = PH_DONE;
                end
              end
              PH_SIGN, PH_DIGITS: begin
                if (is_digit) add_rate_digit(ch);
                else rate_phase = PH_DONE;
              end
              default: ;
            endcase
          end else if (ch == CH_F) begin
            f_seen = 1'b1;
          end
        end
      end
      line_len++;
    end
  endfunction

  function automatic void report_error(input string msg);
    if (errors < MAX_REPORTS) $display("%0t: %s", $time, msg);
    errors++;
  endfunction

  function automatic void check_rate_cmd();
    rate_cmd_t got;
    rate_cmd_t want;
    got = '{cmd_if.command_valid, cmd_if.motor_select, cmd_if.step_rate};
    if (expected_cmds.size() == 0) begin
      report_error($sformatf("command with none pending: valid=%0b motor=%0d rate=%0d",
                             got.command_valid, got.motor_select, got.step_rate));
    end else begin
      want = expected_cmds.pop_front();
      if (got.command_valid !== want.command_valid ||
          got.motor_select !== want.motor_select ||
          got.step_rate !== want.step_rate) begin
        report_error($sformatf(
          "command mismatch: valid exp %0b got %0b, motor exp %0d got %0d, rate exp %0d got %0d",
          want.command_valid, got.command_valid, want.motor_select, got.motor_select,
          want.step_rate, got.step_rate));
      end
    end
  endfunction

  // check results, predict from accepted bytes, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (cmd_if.valid && cmd_if.ready) check_rate_cmd();
      if (byte_if.valid && byte_if.ready) parse_rx_byte(byte_if.rx_byte);
      if ((cmd_if.valid && cmd_if.ready) || (byte_if.valid && byte_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout after %0d cycles without a word", quiet_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    cmd_if.ready <= !sink_hold && ($urandom_range(0, 99) >= snk_idle_pct);
  end

  task automatic send_byte(input logic [7:0] ch);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      byte_if.valid   <= 1'b0;
      byte_if.rx_byte <= 8'($urandom_range(0, 255));
      @(posedge clk);
    end
    byte_if.valid   <= 1'b1;
    byte_if.rx_byte <= ch;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_byte(CH_NL);
  endtask

  function automatic logic [7:0] text_byte(input logic allow_f);
    logic [7:0] ch;
    ch = 8'($urandom_range(1, 255));
    while (ch == CH_NL || (!allow_f && ch == CH_F)) ch = 8'($urandom_range(1, 255));
    return ch;
  endfunction

  function automatic logic [7:0] space_byte();
    case ($urandom_range(0, 4))
      0: return CH_TAB;
      1: return CH_VT;
      2: return CH_FF;
      3: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic void build_random_line();
    int unsigned kind;
    int unsigned n;
    line_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      n = $urandom_range(0, 40);
      repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      line_buf.push_back(($urandom_range(0, 19) == 0) ? text_byte(1'b1) : CH_M);
      line_buf.push_back(($urandom_range(0, 9) == 0) ? text_byte(1'b1) :
                         8'(CH_ZERO + $urandom_range(0, 3)));
      n = (kind < 22) ? $urandom_range(24, 40) : $urandom_range(0, 3);
      repeat (n) line_buf.push_back(text_byte(1'b0));
      if ($urandom_range(0, 19) != 0) line_buf.push_back(CH_F);
      n = $urandom_range(0, 2);
      repeat (n) line_buf.push_back(space_byte());
      case ($urandom_range(0, 2))
        0: line_buf.push_back(CH_PLUS);
        1: line_buf.push_back(CH_MINUS);
        default: ;
      endcase
      n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      repeat (n) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) line_buf.push_back(text_byte(1'b1));
      end
      if ($urandom_range(0, 19) == 0) line_buf.insert($urandom_range(0, line_buf.size()), CH_NUL);
    end
    line_buf.push_back(CH_NL);
  endfunction

  task automatic test_directed_lines();
    src_idle_pct = 10;
    snk_idle_pct = 48;
    send_line("M0F0");
    send_line("M3F+32767");
    send_line("M1F-32768");
    send_line("M2F99999");
    send_line("M2F-123456");
    send_line("M");
    send_line("");
    send_line("X1F5");
    send_line("M4F5");
    send_line("M1 25");
    send_line("F1F5");
    send_line("M1F");
    send_line("M3F-");
    send_line("M1FF5");
    send_text("M1F");
    send_byte(CH_TAB);
    send_byte(CH_VT);
    send_byte(CH_FF);
    send_byte(CH_CR);
    send_line(" -12x3");
    send_text("M2");
    send_byte(CH_NUL);
    send_line("F7");
    send_text("M3F12");
    send_byte(CH_NUL);
    send_line("9");
    send_text("M1");
    repeat (LINE_CAP - 4) send_byte(CH_SPACE);
    send_line("F7");
    send_text("M0F+");
    send_byte(8'hFF);
    send_line("1");
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned snk_pct,
                                     input int unsigned n_bytes);
    int unsigned sent;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < n_bytes) begin
      build_random_line();
      foreach (line_buf[i]) send_byte(line_buf[i]);
      sent += line_buf.size();
    end
  endtask

  task automatic test_sink_holdoff();
    src_idle_pct = 0;
    snk_idle_pct = 10;
    fork
      begin
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
      end
      begin
        repeat (40) begin
          send_line($sformatf("M%0dF%0d", $urandom_range(0, 3),
                              int'($urandom_range(0, 65535)) - 32768));
        end
      end
    join
  endtask

  initial begin
    byte_if.valid   = 1'b0;
    byte_if.rx_byte = '0;
    cmd_if.ready    = 1'b0;
    sink_hold       = 1'b0;
    src_idle_pct    = 0;
    snk_idle_pct    = 0;
    quiet_cycles    = 0;
    errors          = 0;
    bytes_taken     = 0;
    lines_seen      = 0;
    valid_cmds      = 0;
    limit_rates     = 0;
    clear_line();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_lines();
    test_random_traffic(10, 48, 400);
    test_random_traffic(48, 10, 400);
    test_sink_holdoff();
    test_random_traffic(0, 0, 400);

    byte_if.valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Parsed %0d bytes in %0d lines: %0d valid commands, %0d at the rate limit.",
             bytes_taken, lines_seen, valid_cmds, limit_rates);
    $display("Both sides idled in turn; one %0d-cycle output stall; %0d mismatches.",
             HOLD_CYCLES, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
